@@ rtl/lfmc_pkg.sv @@
// Shared types, constants and helper functions for the leg force to motor current block.
package lfmc_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [19:0] TWO_PI_Q16 = 20'sd411775;
    localparam logic [15:0] QUARTER_TURN = 16'h4000;
    localparam logic signed [16:0] SINE_ONE = 17'sd32768;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LINK_ONE_LENGTH      = 3'd0,
        CFG_LINK_TWO_LENGTH      = 3'd1,
        CFG_SPRING_STIFFNESS     = 3'd2,
        CFG_INV_SPRING_STIFFNESS = 3'd3,
        CFG_INV_GEAR_RATIO       = 3'd4,
        CFG_INV_TORQUE_CONSTANT  = 3'd5,
        CFG_PROP_GAIN            = 3'd6,
        CFG_DERIV_GAIN           = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] link_one_length;
        logic [15:0] link_two_length;
        logic [23:0] spring_stiffness;
        logic [23:0] inv_spring_stiffness;
        logic [23:0] inv_gear_ratio;
        logic [23:0] inv_torque_constant;
        logic [23:0] prop_gain;
        logic [23:0] deriv_gain;
    } cfg_t;

    // Item as it enters the trig stages
    typedef struct packed {
        logic [15:0]        len;
        logic signed [23:0] fx;
        logic signed [23:0] fz;
        logic signed [23:0] dfx;
        logic signed [23:0] dfz;
        logic [15:0]        th;
        logic signed [16:0] w;
        logic signed [15:0] d;
        logic signed [16:0] dv;
    } item_t;

    // Item with sine and cosine attached
    typedef struct packed {
        logic [15:0]        len;
        logic signed [23:0] fx;
        logic signed [23:0] fz;
        logic signed [23:0] dfx;
        logic signed [23:0] dfz;
        logic signed [16:0] s;
        logic signed [16:0] c;
        logic signed [16:0] w;
        logic signed [15:0] d;
        logic signed [16:0] dv;
    } trig_t;

    // Spring torque results handed to the current stages
    typedef struct packed {
        logic signed [31:0] dtau;
        logic signed [32:0] defl_des;
        logic signed [37:0] ff;
        logic signed [19:0] defl;
        logic signed [16:0] dv;
        logic               sat;
    } torq_t;

    // Quarter wave sine entry in Q1.15, integer Taylor series
    function automatic logic [15:0] sine_entry(input int unsigned i, input int unsigned bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (64'(i) * HALF_PI_Q30) >> bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + $signed(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - $signed(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        sum = (sum + 64'sd16384) >>> 15;
        if (sum > 64'sd32767)
        begin
            sum = 64'sd32767;
        end
        return sum[15:0];
    endfunction

    // Clip to signed 32 bits, flag in the top bit
    function automatic logic [32:0] sat32(input logic signed [63:0] x);
        logic [32:0] r;
        if (x > 64'sd2147483647)
        begin
            r = {1'b1, 32'h7fffffff};
        end
        else if (x < -64'sd2147483648)
        begin
            r = {1'b1, 32'h80000000};
        end
        else
        begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

    // Clip to signed 24 bits, flag in the top bit
    function automatic logic [24:0] sat24(input logic signed [63:0] x);
        logic [24:0] r;
        if (x > 64'sd8388607)
        begin
            r = {1'b1, 24'h7fffff};
        end
        else if (x < -64'sd8388608)
        begin
            r = {1'b1, 24'h800000};
        end
        else
        begin
            r = {1'b0, x[23:0]};
        end
        return r;
    endfunction

endpackage

@@ rtl/lfmc_trig.sv @@
// Sine and cosine lookup stages: quarter wave ROM read and sign fold.
module lfmc_trig
    import lfmc_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = 10
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  item_t item,
    output logic  out_valid,
    output trig_t tout
);

    localparam int unsigned DEPTH = 1 << SINE_TABLE_BITS;

    logic [15:0] sine_rom [DEPTH];

    // Fill the ROM with constant entries
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_rom
        assign sine_rom[g] = sine_entry(g, SINE_TABLE_BITS);
    end

    logic [15:0]                th_c;
    logic [SINE_TABLE_BITS-1:0] idx_s;
    logic [SINE_TABLE_BITS-1:0] idx_c;
    logic [SINE_TABLE_BITS-1:0] addr_s;
    logic [SINE_TABLE_BITS-1:0] addr_c;

    // Fold the angle into the first quadrant
    assign th_c   = item.th + QUARTER_TURN;
    assign idx_s  = item.th[13 -: SINE_TABLE_BITS];
    assign idx_c  = th_c[13 -: SINE_TABLE_BITS];
    assign addr_s = item.th[14] ? (~idx_s + 1'b1) : idx_s;
    assign addr_c = th_c[14] ? (~idx_c + 1'b1) : idx_c;

    logic        v0_reg;
    logic [15:0] rom_s_reg;
    logic [15:0] rom_c_reg;
    logic        full_s_reg;
    logic        full_c_reg;
    logic        neg_s_reg;
    logic        neg_c_reg;
    item_t       item_reg;

    // Read the ROM and hold the rest of the item
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rom_s_reg  <= sine_rom[addr_s];
            rom_c_reg  <= sine_rom[addr_c];
            full_s_reg <= item.th[14] && (idx_s == '0);
            full_c_reg <= th_c[14] && (idx_c == '0);
            neg_s_reg  <= item.th[15];
            neg_c_reg  <= th_c[15];
            item_reg   <= item;
        end
    end

    logic signed [16:0] mag_s;
    logic signed [16:0] mag_c;

    assign mag_s = full_s_reg ? SINE_ONE : $signed({1'b0, rom_s_reg});
    assign mag_c = full_c_reg ? SINE_ONE : $signed({1'b0, rom_c_reg});

    logic v1_reg;

    // Apply quadrant sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tout.len <= item_reg.len;
            tout.fx  <= item_reg.fx;
            tout.fz  <= item_reg.fz;
            tout.dfx <= item_reg.dfx;
            tout.dfz <= item_reg.dfz;
            tout.s   <= neg_s_reg ? -mag_s : mag_s;
            tout.c   <= neg_c_reg ? -mag_c : mag_c;
            tout.w   <= item_reg.w;
            tout.d   <= item_reg.d;
            tout.dv  <= item_reg.dv;
        end
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    assign out_valid = v1_reg;

endmodule

@@ rtl/lfmc_torque.sv @@
// Jacobian stages: spring torque, torque rate, desired deflection and feedforward.
module lfmc_torque
    import lfmc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  logic  in_valid,
    input  trig_t tin,
    input  cfg_t  cfg,
    output logic  out_valid,
    output torq_t tout
);

    // Stage A: force by sine and cosine products
    logic signed [40:0] a_fzs_reg, a_fxc_reg, a_fxs_reg, a_fzc_reg, a_dfzs_reg, a_dfxc_reg;
    logic signed [16:0] a_w_reg;
    logic signed [15:0] a_d_reg;
    logic signed [16:0] a_dv_reg;
    logic [15:0]        a_len_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_fzs_reg  <= tin.fz * tin.s;
            a_fxc_reg  <= tin.fx * tin.c;
            a_fxs_reg  <= tin.fx * tin.s;
            a_fzc_reg  <= tin.fz * tin.c;
            a_dfzs_reg <= tin.dfz * tin.s;
            a_dfxc_reg <= tin.dfx * tin.c;
            a_w_reg    <= tin.w;
            a_d_reg    <= tin.d;
            a_dv_reg   <= tin.dv;
            a_len_reg  <= tin.len;
        end
    end

    // Stage B: combine products, convert deflection to radians
    logic signed [41:0] b_tq_reg, b_rq_reg, b_dq_reg;
    logic signed [19:0] b_defl_reg;
    logic signed [16:0] b_w_reg;
    logic signed [16:0] b_dv_reg;
    logic [15:0]        b_len_reg;
    logic signed [35:0] defl_prod;

    assign defl_prod = a_d_reg * TWO_PI_Q16;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_tq_reg   <= a_fzs_reg - a_fxc_reg;
            b_rq_reg   <= a_fxs_reg + a_fzc_reg;
            b_dq_reg   <= a_dfzs_reg - a_dfxc_reg;
            b_defl_reg <= defl_prod[35:16];
            b_w_reg    <= a_w_reg;
            b_dv_reg   <= a_dv_reg;
            b_len_reg  <= a_len_reg;
        end
    end

    // Stage C: scale by link length and leg rate, spring by deflection
    logic signed [58:0] c_tql_reg;
    logic signed [58:0] c_rqw_reg;
    logic signed [39:0] c_dq4_reg;
    logic signed [44:0] c_ksd_reg;
    logic signed [19:0] c_defl_reg;
    logic signed [16:0] c_dv_reg;
    logic [15:0]        c_len_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_tql_reg  <= b_tq_reg * $signed({1'b0, b_len_reg});
            c_rqw_reg  <= b_rq_reg * b_w_reg;
            c_dq4_reg  <= b_dq_reg[41:2];
            c_ksd_reg  <= $signed({1'b0, cfg.spring_stiffness}) * b_defl_reg;
            c_defl_reg <= b_defl_reg;
            c_dv_reg   <= b_dv_reg;
            c_len_reg  <= b_len_reg;
        end
    end

    // Stage D: clip tau, form inner rate term
    logic signed [31:0] d_tau_reg;
    logic signed [49:0] d_inner_reg;
    logic signed [36:0] d_ffa_reg;
    logic signed [19:0] d_defl_reg;
    logic signed [16:0] d_dv_reg;
    logic [15:0]        d_len_reg;
    logic               d_sat_reg;
    logic [32:0]        tau_sat;

    assign tau_sat = sat32(64'($signed(c_tql_reg[58:23])));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_tau_reg   <= tau_sat[31:0];
            d_sat_reg   <= tau_sat[32];
            d_inner_reg <= $signed(c_rqw_reg[58:10]) + c_dq4_reg;
            d_ffa_reg   <= c_ksd_reg[44:8];
            d_defl_reg  <= c_defl_reg;
            d_dv_reg    <= c_dv_reg;
            d_len_reg   <= c_len_reg;
        end
    end

    // Stage E: rate by length, tau by compliance, feedforward by gear
    logic signed [66:0] e_innerl_reg;
    logic signed [56:0] e_tauiks_reg;
    logic signed [61:0] e_ffig_reg;
    logic signed [19:0] e_defl_reg;
    logic signed [16:0] e_dv_reg;
    logic               e_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_innerl_reg <= d_inner_reg * $signed({1'b0, d_len_reg});
            e_tauiks_reg <= d_tau_reg * $signed({1'b0, cfg.inv_spring_stiffness});
            e_ffig_reg   <= d_ffa_reg * $signed({1'b0, cfg.inv_gear_ratio});
            e_defl_reg   <= d_defl_reg;
            e_dv_reg     <= d_dv_reg;
            e_sat_reg    <= d_sat_reg;
        end
    end

    // Stage F: clip dtau, reduce scaled terms
    logic [32:0] dtau_sat;

    assign dtau_sat = sat32(64'($signed(e_innerl_reg[66:21])));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tout.dtau     <= dtau_sat[31:0];
            tout.sat      <= e_sat_reg | dtau_sat[32];
            tout.defl_des <= e_tauiks_reg[56:24];
            tout.ff       <= e_ffig_reg[61:24];
            tout.defl     <= e_defl_reg;
            tout.dv       <= e_dv_reg;
        end
    end

    logic va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= in_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
        end
    end

    assign out_valid = vf_reg;

endmodule

@@ rtl/lfmc_current.sv @@
// PD law stages: torque sum, saturation and conversion to motor current.
module lfmc_current
    import lfmc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  torq_t              tin,
    input  cfg_t               cfg,
    output logic               out_valid,
    output logic signed [23:0] motor_current,
    output logic               current_saturated
);

    // Stage G: desired rate product, deflection error
    logic signed [56:0] g_ratep_reg;
    logic signed [33:0] g_pdiff_reg;
    logic signed [37:0] g_ff_reg;
    logic signed [16:0] g_dv_reg;
    logic               g_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_ratep_reg <= tin.dtau * $signed({1'b0, cfg.inv_spring_stiffness});
            g_pdiff_reg <= tin.defl_des - tin.defl;
            g_ff_reg    <= tin.ff;
            g_dv_reg    <= tin.dv;
            g_sat_reg   <= tin.sat;
        end
    end

    // Stage H: proportional product, rate error
    logic signed [58:0] h_pprod_reg;
    logic signed [33:0] h_ddiff_reg;
    logic signed [37:0] h_ff_reg;
    logic               h_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_pprod_reg <= $signed({1'b0, cfg.prop_gain}) * g_pdiff_reg;
            h_ddiff_reg <= $signed(g_ratep_reg[56:24]) - $signed({g_dv_reg, 8'h00});
            h_ff_reg    <= g_ff_reg;
            h_sat_reg   <= g_sat_reg;
        end
    end

    // Stage I: derivative product
    logic signed [58:0] i_dprod_reg;
    logic signed [50:0] i_pt_reg;
    logic signed [37:0] i_ff_reg;
    logic               i_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_dprod_reg <= $signed({1'b0, cfg.deriv_gain}) * h_ddiff_reg;
            i_pt_reg    <= h_pprod_reg[58:8];
            i_ff_reg    <= h_ff_reg;
            i_sat_reg   <= h_sat_reg;
        end
    end

    // Stage J: sum and clip motor torque
    logic signed [52:0] tsum;
    logic [32:0]        torque_sat;
    logic signed [31:0] j_torque_reg;
    logic               j_sat_reg;

    assign tsum       = i_ff_reg + i_pt_reg + $signed(i_dprod_reg[58:8]);
    assign torque_sat = sat32(64'(tsum));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            j_torque_reg <= torque_sat[31:0];
            j_sat_reg    <= i_sat_reg | torque_sat[32];
        end
    end

    // Stage K: torque to current
    logic signed [56:0] k_tprod_reg;
    logic               k_sat_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_tprod_reg <= j_torque_reg * $signed({1'b0, cfg.inv_torque_constant});
            k_sat_reg   <= j_sat_reg;
        end
    end

    // Stage L: clip current into the output register
    logic [24:0] cur_sat;

    assign cur_sat = sat24(64'($signed(k_tprod_reg[56:24])));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            motor_current     <= cur_sat[23:0];
            current_saturated <= k_sat_reg | cur_sat[24];
        end
    end

    logic vg_reg, vh_reg, vi_reg, vj_reg, vk_reg, vl_reg;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
            vi_reg <= 1'b0;
            vj_reg <= 1'b0;
            vk_reg <= 1'b0;
            vl_reg <= 1'b0;
        end
        else if (en)
        begin
            vg_reg <= in_valid;
            vh_reg <= vg_reg;
            vi_reg <= vh_reg;
            vj_reg <= vi_reg;
            vk_reg <= vj_reg;
            vl_reg <= vk_reg;
        end
    end

    assign out_valid = vl_reg;

endmodule

@@ rtl/leg_force_to_motor_current.sv @@
// Top level: configuration registers, input folding and the current pipeline.
//
//  channel   direction  handshake               payload
//  input     in         in_valid / in_ready     half_select .. body_pitch_rate
//  result    out        out_valid / out_ready   motor_current, current_saturated
//  config    in         cfg_write               cfg_index, cfg_data
//
// The pipeline has 2 trig stages (ROM read, sign fold), 6 torque stages
// and 6 current stages, each holding at most one multiplier per path.
// One item enters per cycle while in_ready is high; the pipeline advances as
// a whole when the output is empty or being taken; a stall holds every stage.
// Reset clears valid bits and loads the configuration defaults; the sine ROM
// is constant and needs no fill.
module leg_force_to_motor_current
    import lfmc_pkg::*;
#(
    parameter int unsigned SINE_TABLE_BITS = 10
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   half_select,
    input  logic signed [23:0]     force_x,
    input  logic signed [23:0]     force_z,
    input  logic signed [23:0]     force_x_rate,
    input  logic signed [23:0]     force_z_rate,
    input  logic signed [15:0]     leg_angle,
    input  logic signed [15:0]     motor_angle,
    input  logic signed [15:0]     leg_velocity,
    input  logic signed [15:0]     motor_velocity,
    input  logic signed [15:0]     body_pitch,
    input  logic signed [15:0]     body_pitch_rate,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [23:0]     motor_current,
    output logic                   current_saturated,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t cfg_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.link_one_length      <= 16'd32768;
            cfg_reg.link_two_length      <= 16'd32768;
            cfg_reg.spring_stiffness     <= 24'd409600;
            cfg_reg.inv_spring_stiffness <= 24'd10486;
            cfg_reg.inv_gear_ratio       <= 24'd335544;
            cfg_reg.inv_torque_constant  <= 24'd541400;
            cfg_reg.prop_gain            <= 24'd256000;
            cfg_reg.deriv_gain           <= 24'd2048;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LINK_ONE_LENGTH:      cfg_reg.link_one_length      <= cfg_data[15:0];
                CFG_LINK_TWO_LENGTH:      cfg_reg.link_two_length      <= cfg_data[15:0];
                CFG_SPRING_STIFFNESS:     cfg_reg.spring_stiffness     <= cfg_data;
                CFG_INV_SPRING_STIFFNESS: cfg_reg.inv_spring_stiffness <= cfg_data;
                CFG_INV_GEAR_RATIO:       cfg_reg.inv_gear_ratio       <= cfg_data;
                CFG_INV_TORQUE_CONSTANT:  cfg_reg.inv_torque_constant  <= cfg_data;
                CFG_PROP_GAIN:            cfg_reg.prop_gain            <= cfg_data;
                CFG_DERIV_GAIN:           cfg_reg.deriv_gain           <= cfg_data;
            endcase
        end
    end

    // Advance the pipeline unless a result is stuck at the output
    logic en;

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Fold input angles and rates
    item_t item;

    always_comb
    begin
        item.len = half_select ? cfg_reg.link_one_length : cfg_reg.link_two_length;
        item.fx  = force_x;
        item.fz  = force_z;
        item.dfx = force_x_rate;
        item.dfz = force_z_rate;
        item.th  = leg_angle + body_pitch;
        item.w   = 17'(leg_velocity) + 17'(body_pitch_rate);
        item.d   = motor_angle - leg_angle;
        item.dv  = 17'(motor_velocity) - 17'(leg_velocity);
    end

    logic  trig_valid;
    trig_t trig;
    logic  torq_valid;
    torq_t torq;

    lfmc_trig #(
        .SINE_TABLE_BITS (SINE_TABLE_BITS)
    ) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (in_valid),
        .item      (item),
        .out_valid (trig_valid),
        .tout      (trig)
    );

    lfmc_torque u_torque (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (trig_valid),
        .tin       (trig),
        .cfg       (cfg_reg),
        .out_valid (torq_valid),
        .tout      (torq)
    );

    lfmc_current u_current (
        .clk               (clk),
        .rst_n             (rst_n),
        .en                (en),
        .in_valid          (torq_valid),
        .tin               (torq),
        .cfg               (cfg_reg),
        .out_valid         (out_valid),
        .motor_current     (motor_current),
        .current_saturated (current_saturated)
    );

endmodule
